FILE: rtl/sbre_pkg.sv
package sbre_pkg;

	localparam int SHADOW_BYTES = 4096;
	localparam int MAX_RANGE    = 256;

	localparam int ADDR_W  = $clog2(SHADOW_BYTES);
	localparam int BADDR_W = ADDR_W + 3;
	localparam int LEN_W   = 9;

	localparam logic [1:0] OP_MARK   = 2'd0;
	localparam logic [1:0] OP_UNMARK = 2'd1;
	localparam logic [1:0] OP_CHECK  = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	function automatic logic [3:0] popcount8(input logic [7:0] v);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < 8; i++) begin
			n = n + {3'b000, v[i]};
		end
		return n;
	endfunction

endpackage

FILE: rtl/shadow_bitmap_range_engine.sv
// Channel   Direction  Handshake             Payload
// request   in         req_valid/req_stall   opcode, start_address, byte_count
// response  out        rsp_valid/rsp_stall   marked_count
//
// A request touching W shadow bytes, W = ceil((start_address%8 + n)/8) with n = byte_count clamped
// to 256, passes from acceptance through one fetch state, W read-modify-write steps through
// the single shadow RAM port pair, one completion state and back to idle; empty or
// unused-opcode requests skip straight to completion.
// After reset a clearing pass zeroes the 4096-entry shadow RAM, one entry a cycle;
// req_stall stays high until the pass completes.
// The response sits in an output register; a stalled response holds the next
// completion in the done state until the register frees.
module shadow_bitmap_range_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [1:0]                   opcode,
	input  logic [sbre_pkg::BADDR_W-1:0] start_address,
	input  logic [sbre_pkg::LEN_W-1:0]   byte_count,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [sbre_pkg::LEN_W-1:0]   marked_count
);
	import sbre_pkg::*;

	localparam logic [2:0] ST_CLR   = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_FETCH = 3'd2;
	localparam logic [2:0] ST_RUN   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	localparam logic [LEN_W-1:0]  MAX_LEN  = LEN_W'(MAX_RANGE);
	localparam logic [ADDR_W-1:0] LAST_ENT = ADDR_W'(SHADOW_BYTES - 1);

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] clr_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] wr_addr_q;
	logic [1:0]        op_q;
	logic [2:0]        lo_q;
	logic [LEN_W-1:0]  rem_q;
	logic [LEN_W-1:0]  cnt_q;
	logic              rsp_valid_q;
	logic [LEN_W-1:0]  rsp_cnt_q;

	logic [7:0] mem [SHADOW_BYTES];
	logic [7:0] rdata_q;

	logic              accept;
	logic [LEN_W-1:0]  len;
	logic [LEN_W:0]    top;
	logic              last;
	logic [7:0]        mask;
	logic [7:0]        new_data;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [7:0]        mem_wdata;
	logic              slot_free;
	logic              rsp_load;

	assign req_stall    = (state_q != ST_IDLE);
	assign accept       = req_valid && !req_stall;
	assign rsp_valid    = rsp_valid_q;
	assign marked_count = rsp_cnt_q;
	assign slot_free    = !rsp_valid_q || !rsp_stall;
	assign rsp_load     = (state_q == ST_DONE) && slot_free;

	assign len = (byte_count > MAX_LEN) ? MAX_LEN : byte_count;

	// bits lo_q .. lo_q+rem_q-1 of the current shadow byte, clipped at bit 7
	assign top  = {{(LEN_W-2){1'b0}}, lo_q} + {1'b0, rem_q};
	assign last = (top <= (LEN_W+1)'(8));
	assign mask = (8'hFF << lo_q) & ((top >= (LEN_W+1)'(8)) ? 8'hFF : ~(8'hFF << top[2:0]));

	always_comb begin
		unique case (op_q)
			OP_MARK:   new_data = rdata_q | mask;
			OP_UNMARK: new_data = rdata_q & ~mask;
			default:   new_data = rdata_q;
		endcase
	end

	assign mem_we    = (state_q == ST_CLR) ||
	                   ((state_q == ST_RUN) && ((op_q == OP_MARK) || (op_q == OP_UNMARK)));
	assign mem_waddr = (state_q == ST_CLR) ? clr_q : wr_addr_q;
	assign mem_wdata = (state_q == ST_CLR) ? 8'h00 : new_data;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == LAST_ENT) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if ((len == '0) || (opcode == OP_UNUSED)) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_FETCH;
						end
					end
				end
				ST_FETCH: state_q <= ST_RUN;
				ST_RUN: begin
					if (last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q   <= opcode;
					addr_q <= start_address[BADDR_W-1:3];
					lo_q   <= start_address[2:0];
					rem_q  <= len;
					cnt_q  <= '0;
				end
			end
			ST_FETCH: begin
				wr_addr_q <= addr_q;
				addr_q    <= addr_q + ADDR_W'(1);
			end
			ST_RUN: begin
				wr_addr_q <= addr_q;
				addr_q    <= addr_q + ADDR_W'(1);
				lo_q      <= 3'd0;
				rem_q     <= last ? '0 : LEN_W'(top - (LEN_W+1)'(8));
				if (op_q == OP_CHECK) begin
					cnt_q <= cnt_q + {{(LEN_W-4){1'b0}}, popcount8(rdata_q & mask)};
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					rsp_cnt_q <= cnt_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("accepted request did not start work");

	a_write_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ((state_q == ST_CLR) || (state_q == ST_RUN)))
		else $error("shadow RAM written outside clear or run");

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (addr_q != wr_addr_q))
		else $error("read and write address collide during run");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_cnt_q <= MAX_LEN))
		else $error("response count exceeds range limit");

endmodule

FILE: tb/shadow_bitmap_range_engine_tb.sv
`timescale 1ns / 1ps

module shadow_bitmap_range_engine_tb;
	import sbre_pkg::*;

	localparam int         WINDOW      = SHADOW_BYTES * 8;
	localparam int         CYCLE_LIMIT = 1_000_000;
	localparam int         RANDOM_REQS = 1300;

	class bitmap_scoreboard;
		bit [7:0]         shadow_bytes [SHADOW_BYTES];
		logic [LEN_W-1:0] expected_counts [$];
		int               mismatches;

		function new();
			foreach (shadow_bytes[i]) shadow_bytes[i] = 8'h00;
			mismatches = 0;
		endfunction

		// Apply an accepted request to the shadow copy and queue its count.
		function void note_request(logic [1:0] op, logic [BADDR_W-1:0] addr,
				logic [LEN_W-1:0] n);
			int unsigned len;
			int unsigned a;
			int unsigned total;
			len = (n > MAX_RANGE) ? MAX_RANGE : n;
			total = 0;
			for (int unsigned k = 0; k < len; k++) begin
				a = (addr + k) % WINDOW;
				case (op)
					OP_MARK:   shadow_bytes[a >> 3][a & 7] = 1'b1;
					OP_UNMARK: shadow_bytes[a >> 3][a & 7] = 1'b0;
					OP_CHECK:  total += shadow_bytes[a >> 3][a & 7];
					default:   ;
				endcase
			end
			expected_counts.push_back(total[LEN_W-1:0]);
		endfunction

		function void check_count(logic [LEN_W-1:0] actual);
			logic [LEN_W-1:0] want;
			if (expected_counts.size() == 0) begin
				$error("unexpected response, marked_count=%0d", actual);
				mismatches++;
				return;
			end
			want = expected_counts.pop_front();
			if (actual !== want) begin
				$error("marked_count: expected %0d, actual %0d", want, actual);
				mismatches++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	logic [1:0]         opcode;
	logic [BADDR_W-1:0] start_address;
	logic [LEN_W-1:0]   byte_count;
	logic               rsp_valid;
	logic               rsp_stall;
	logic [LEN_W-1:0]   marked_count;

	bitmap_scoreboard tracker = new();
	bit               calm = 1'b0;
	int               cycle_count = 0;

	shadow_bitmap_range_engine u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.opcode        (opcode),
		.start_address (start_address),
		.byte_count    (byte_count),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.marked_count  (marked_count)
	);

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		opcode        = OP_MARK;
		start_address = '0;
		byte_count    = '0;
		rsp_stall     = 1'b0;
	end

	always #5 clk = ~clk;

	// mostly short gaps, a few long ones; none at all in calm stretches
	function automatic int draw_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_request(logic [1:0] op, logic [BADDR_W-1:0] addr,
			logic [LEN_W-1:0] n);
		int gap;
		gap = draw_gap();
		repeat (gap) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req_valid     <= 1'b1;
		opcode        <= op;
		start_address <= addr;
		byte_count    <= n;
		do @(posedge clk); while (req_stall !== 1'b0);
		tracker.note_request(op, addr, n);
	endtask

	// response side: random stall bursts, then take one response
	initial begin
		int n;
		forever begin
			n = draw_gap();
			repeat (n) begin
				@(negedge clk);
				rsp_stall <= 1'b1;
			end
			@(negedge clk);
			rsp_stall <= 1'b0;
			do @(posedge clk); while (rsp_valid !== 1'b1);
			tracker.check_count(marked_count);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int          r;
		int          hot_base;
		int          addr;
		logic [1:0]  op;
		logic [LEN_W-1:0] n;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty map, single bits, byte crossings, wrap, clamp, unused op
		send_request(OP_CHECK,  15'd0,     9'd256);
		send_request(OP_MARK,   15'd0,     9'd0);
		send_request(OP_MARK,   15'd3,     9'd1);
		send_request(OP_CHECK,  15'd0,     9'd8);
		send_request(OP_MARK,   15'd5,     9'd13);
		send_request(OP_CHECK,  15'd0,     9'd32);
		send_request(OP_MARK,   15'd32760, 9'd20);
		send_request(OP_CHECK,  15'd32750, 9'd40);
		send_request(OP_MARK,   15'd100,   9'd256);
		send_request(OP_CHECK,  15'd100,   9'd511);
		send_request(OP_UNMARK, 15'd150,   9'd300);
		send_request(OP_CHECK,  15'd96,    9'd320);
		send_request(OP_UNUSED, 15'd200,   9'd50);
		send_request(OP_CHECK,  15'd100,   9'd256);
		send_request(OP_UNMARK, 15'd32767, 9'd1);
		send_request(OP_CHECK,  15'd32767, 9'd2);
		send_request(OP_MARK,   15'd16,    9'd8);
		send_request(OP_UNMARK, 15'd17,    9'd6);
		send_request(OP_CHECK,  15'd16,    9'd8);
		send_request(OP_CHECK,  15'd0,     9'd0);
		send_request(OP_UNMARK, 15'd32760, 9'd20);
		send_request(OP_CHECK,  15'd32760, 9'd20);
		send_request(OP_MARK,   15'h7FFF,  9'h1FF);
		send_request(OP_CHECK,  15'h7FFF,  9'h1FF);
		send_request(OP_UNUSED, 15'h7FFF,  9'h1FF);

		hot_base = 0;
		for (int i = 0; i < RANDOM_REQS; i++) begin
			// keep most traffic in a small moving region so checks see marks
			if (i % 100 == 0) begin
				calm = ($urandom_range(0, 3) == 0);
				case ($urandom_range(0, 3))
					0: hot_base = 0;
					1: hot_base = WINDOW - 384;
					2: hot_base = $urandom_range(0, WINDOW - 1) & ~7;
					default: hot_base = 4096;
				endcase
			end

			r = $urandom_range(0, 99);
			if (r < 35)
				op = OP_MARK;
			else if (r < 55)
				op = OP_UNMARK;
			else if (r < 95)
				op = OP_CHECK;
			else
				op = OP_UNUSED;

			if ($urandom_range(0, 9) < 7)
				addr = (hot_base + $urandom_range(0, 767)) % WINDOW;
			else
				addr = $urandom_range(0, WINDOW - 1);

			r = $urandom_range(0, 99);
			if (r < 10)
				n = 9'd0;
			else if (r < 60)
				n = LEN_W'($urandom_range(1, 40));
			else if (r < 85)
				n = LEN_W'($urandom_range(41, 256));
			else if (r < 95)
				n = LEN_W'($urandom_range(257, 511));
			else
				n = 9'd256;

			send_request(op, addr[BADDR_W-1:0], n);
		end

		@(negedge clk);
		req_valid <= 1'b0;

		while (tracker.expected_counts.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		if (tracker.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
